[rtl/core/tfn_pkg.sv]
// shared widths and sideband type for the triangle face normal pipeline
package tfn_pkg;

    localparam int CoordW    = 24;
    localparam int IndexW    = 24;
    localparam int EdgeW     = CoordW + 1;
    localparam int ProdW     = 2 * EdgeW;
    localparam int CrossW    = ProdW + 1;
    localparam int MagW      = 49;
    localparam int LoW       = 25;
    localparam int HiW       = MagW - LoW;
    localparam int SqW       = 2 * MagW;
    localparam int SumW      = SqW + 2;
    localparam int RootSteps = 16;
    localparam int AccW      = SumW + RootSteps;
    localparam int ResW      = 132;
    localparam int FracShift = 30;
    localparam int UnitW     = 16;
    localparam int MagOutW   = 15;
    localparam int Axes      = 3;

    typedef struct packed {
        logic [IndexW-1:0] corner;
        logic [Axes-1:0]   neg;
        logic              zero;
    } side_t;

endpackage

[rtl/core/triangle_face_normal.sv]
// top level: flat unit face normal of one triangle per clock
//
// takes one triangle per clock and returns its unit normal:
// three stages form the edges and the exact cross product, four stages
// square and sum it, sixteen stages resolve the root quotient one bit per
// stage and one stage signs and registers the word. busy is never raised,
// so start may be held high every cycle; every word is shown on the result
// ports for one cycle under done and cannot be held off. the result is
// exact: each component is round-to-nearest (ties away from zero) of
// n_i * 2^14 / |n| in q1.14; a zero cross product gives a zero normal with
// degenerate set. the corner index travels with the word unchanged.
module triangle_face_normal (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic        [tfn_pkg::IndexW-1:0]   corner_base,
    input  logic signed [tfn_pkg::CoordW-1:0]   a_x,
    input  logic signed [tfn_pkg::CoordW-1:0]   a_y,
    input  logic signed [tfn_pkg::CoordW-1:0]   a_z,
    input  logic signed [tfn_pkg::CoordW-1:0]   b_x,
    input  logic signed [tfn_pkg::CoordW-1:0]   b_y,
    input  logic signed [tfn_pkg::CoordW-1:0]   b_z,
    input  logic signed [tfn_pkg::CoordW-1:0]   c_x,
    input  logic signed [tfn_pkg::CoordW-1:0]   c_y,
    input  logic signed [tfn_pkg::CoordW-1:0]   c_z,
    output logic                                done,
    output logic        [tfn_pkg::IndexW-1:0]   corner_index,
    output logic signed [tfn_pkg::UnitW-1:0]    unit_x,
    output logic signed [tfn_pkg::UnitW-1:0]    unit_y,
    output logic signed [tfn_pkg::UnitW-1:0]    unit_z,
    output logic                                degenerate
);
    import tfn_pkg::*;

    logic                     cr_valid;
    logic [IndexW-1:0]        cr_corner;
    logic signed [CrossW-1:0] cr_nx, cr_ny, cr_nz;

    logic                     ns_valid;
    side_t                    ns_side;
    logic [SumW-1:0]          ns_len;
    logic [ResW-1:0]          ns_rx, ns_ry, ns_rz;

    logic                     rt_valid;
    side_t                    rt_side;
    logic [RootSteps-1:0]     rt_q [Axes];

    logic                     done_reg;
    logic [IndexW-1:0]        idx_reg;
    logic signed [UnitW-1:0]  unit_reg [Axes];
    logic                     deg_reg;
    logic signed [UnitW-1:0]  unit_next [Axes];
    logic [RootSteps:0]       q_inc;
    logic [MagOutW-1:0]       k_mag;

    // pipeline never stalls
    assign busy = 1'b0;

    tfn_cross u_cross (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .corner_in  (corner_base),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .c_x        (c_x),
        .c_y        (c_y),
        .c_z        (c_z),
        .out_valid  (cr_valid),
        .corner_out (cr_corner),
        .n_x        (cr_nx),
        .n_y        (cr_ny),
        .n_z        (cr_nz)
    );

    tfn_norm_sq u_norm_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cr_valid),
        .corner_in (cr_corner),
        .n_x       (cr_nx),
        .n_y       (cr_ny),
        .n_z       (cr_nz),
        .out_valid (ns_valid),
        .side_out  (ns_side),
        .len_sq    (ns_len),
        .rem_x     (ns_rx),
        .rem_y     (ns_ry),
        .rem_z     (ns_rz)
    );

    tfn_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ns_valid),
        .side_in   (ns_side),
        .len_sq    (ns_len),
        .rem_x     (ns_rx),
        .rem_y     (ns_ry),
        .rem_z     (ns_rz),
        .out_valid (rt_valid),
        .side_out  (rt_side),
        .quo_x     (rt_q[0]),
        .quo_y     (rt_q[1]),
        .quo_z     (rt_q[2])
    );

    // q = floor(2^15 |n_i| / |n|); rounded q1.14 value is (q + 1) / 2
    always_comb
    begin
        q_inc = '0;
        k_mag = '0;
        for (int k = 0; k < Axes; k++)
        begin
            q_inc = (RootSteps + 1)'(rt_q[k]) + (RootSteps + 1)'(1);
            k_mag = q_inc[MagOutW:1];
            if (rt_side.zero)
            begin
                unit_next[k] = '0;
            end
            else if (rt_side.neg[k])
            begin
                unit_next[k] = -UnitW'(k_mag);
            end
            else
            begin
                unit_next[k] = UnitW'(k_mag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= rt_side.corner;
        deg_reg <= rt_side.zero;
        for (int k = 0; k < Axes; k++)
        begin
            unit_reg[k] <= unit_next[k];
        end
    end

    assign done         = done_reg;
    assign corner_index = idx_reg;
    assign unit_x       = unit_reg[0];
    assign unit_y       = unit_reg[1];
    assign unit_z       = unit_reg[2];
    assign degenerate   = deg_reg;

endmodule

[rtl/core/tfn_cross.sv]
// edge vectors and exact cross product, three register stages
module tfn_cross (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic        [tfn_pkg::IndexW-1:0]   corner_in,
    input  logic signed [tfn_pkg::CoordW-1:0]   a_x,
    input  logic signed [tfn_pkg::CoordW-1:0]   a_y,
    input  logic signed [tfn_pkg::CoordW-1:0]   a_z,
    input  logic signed [tfn_pkg::CoordW-1:0]   b_x,
    input  logic signed [tfn_pkg::CoordW-1:0]   b_y,
    input  logic signed [tfn_pkg::CoordW-1:0]   b_z,
    input  logic signed [tfn_pkg::CoordW-1:0]   c_x,
    input  logic signed [tfn_pkg::CoordW-1:0]   c_y,
    input  logic signed [tfn_pkg::CoordW-1:0]   c_z,
    output logic                                out_valid,
    output logic        [tfn_pkg::IndexW-1:0]   corner_out,
    output logic signed [tfn_pkg::CrossW-1:0]   n_x,
    output logic signed [tfn_pkg::CrossW-1:0]   n_y,
    output logic signed [tfn_pkg::CrossW-1:0]   n_z
);
    import tfn_pkg::*;

    logic                    v1_reg, v2_reg, v3_reg;
    logic [IndexW-1:0]       ci1_reg, ci2_reg, ci3_reg;
    logic signed [EdgeW-1:0] e0x_reg, e0y_reg, e0z_reg, e1x_reg, e1y_reg, e1z_reg;
    logic signed [ProdW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [CrossW-1:0] nx_reg, ny_reg, nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // edges
        ci1_reg <= corner_in;
        e0x_reg <= EdgeW'(b_x) - EdgeW'(a_x);
        e0y_reg <= EdgeW'(b_y) - EdgeW'(a_y);
        e0z_reg <= EdgeW'(b_z) - EdgeW'(a_z);
        e1x_reg <= EdgeW'(c_x) - EdgeW'(a_x);
        e1y_reg <= EdgeW'(c_y) - EdgeW'(a_y);
        e1z_reg <= EdgeW'(c_z) - EdgeW'(a_z);
        // products
        ci2_reg <= ci1_reg;
        p0_reg  <= e0y_reg * e1z_reg;
        p1_reg  <= e0z_reg * e1y_reg;
        p2_reg  <= e0z_reg * e1x_reg;
        p3_reg  <= e0x_reg * e1z_reg;
        p4_reg  <= e0x_reg * e1y_reg;
        p5_reg  <= e0y_reg * e1x_reg;
        // differences
        ci3_reg <= ci2_reg;
        nx_reg  <= CrossW'(p0_reg) - CrossW'(p1_reg);
        ny_reg  <= CrossW'(p2_reg) - CrossW'(p3_reg);
        nz_reg  <= CrossW'(p4_reg) - CrossW'(p5_reg);
    end

    assign out_valid  = v3_reg;
    assign corner_out = ci3_reg;
    assign n_x        = nx_reg;
    assign n_y        = ny_reg;
    assign n_z        = nz_reg;

endmodule

[rtl/core/tfn_norm_sq.sv]
// magnitudes, exact squares in partial products and squared length
module tfn_norm_sq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic        [tfn_pkg::IndexW-1:0]   corner_in,
    input  logic signed [tfn_pkg::CrossW-1:0]   n_x,
    input  logic signed [tfn_pkg::CrossW-1:0]   n_y,
    input  logic signed [tfn_pkg::CrossW-1:0]   n_z,
    output logic                                out_valid,
    output tfn_pkg::side_t                      side_out,
    output logic        [tfn_pkg::SumW-1:0]     len_sq,
    output logic        [tfn_pkg::ResW-1:0]     rem_x,
    output logic        [tfn_pkg::ResW-1:0]     rem_y,
    output logic        [tfn_pkg::ResW-1:0]     rem_z
);
    import tfn_pkg::*;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    side_t                 s1_reg, s2_reg, s3_reg, s4_reg;
    logic [MagW-1:0]       mag_reg [Axes];
    logic [2*LoW-1:0]      pll_reg [Axes];
    logic [LoW+HiW-1:0]    plh_reg [Axes];
    logic [2*HiW-1:0]      phh_reg [Axes];
    logic [SqW-1:0]        sq_reg  [Axes];
    logic [SumW-1:0]       sum_reg;
    logic [ResW-1:0]       rem_reg [Axes];
    logic signed [CrossW-1:0] n_in [Axes];
    logic [CrossW-1:0]     abs_v   [Axes];
    side_t                 s1_next;

    assign n_in[0] = n_x;
    assign n_in[1] = n_y;
    assign n_in[2] = n_z;

    always_comb
    begin
        for (int k = 0; k < Axes; k++)
        begin
            abs_v[k] = n_in[k][CrossW-1] ? CrossW'(-n_in[k]) : CrossW'(n_in[k]);
        end
        s1_next.corner = corner_in;
        s1_next.neg    = {n_z[CrossW-1], n_y[CrossW-1], n_x[CrossW-1]};
        s1_next.zero   = (n_x == '0) && (n_y == '0) && (n_z == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s1_reg;
        s3_reg <= s2_reg;
        s4_reg <= s3_reg;
        for (int k = 0; k < Axes; k++)
        begin
            mag_reg[k] <= abs_v[k][MagW-1:0];
            pll_reg[k] <= mag_reg[k][LoW-1:0] * mag_reg[k][LoW-1:0];
            plh_reg[k] <= mag_reg[k][LoW-1:0] * mag_reg[k][MagW-1:LoW];
            phh_reg[k] <= mag_reg[k][MagW-1:LoW] * mag_reg[k][MagW-1:LoW];
            sq_reg[k]  <= {phh_reg[k], {(2*LoW){1'b0}}}
                        + SqW'({plh_reg[k], {(LoW+1){1'b0}}})
                        + SqW'(pll_reg[k]);
            rem_reg[k] <= ResW'({sq_reg[k], {FracShift{1'b0}}});
        end
        sum_reg <= SumW'(sq_reg[0]) + SumW'(sq_reg[1]) + SumW'(sq_reg[2]);
    end

    assign out_valid = v4_reg;
    assign side_out  = s4_reg;
    assign len_sq    = sum_reg;
    assign rem_x     = rem_reg[0];
    assign rem_y     = rem_reg[1];
    assign rem_z     = rem_reg[2];

endmodule

[rtl/core/tfn_root.sv]
// bit-serial root quotient, one quotient bit per stage for all three axes
module tfn_root (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  tfn_pkg::side_t                      side_in,
    input  logic        [tfn_pkg::SumW-1:0]     len_sq,
    input  logic        [tfn_pkg::ResW-1:0]     rem_x,
    input  logic        [tfn_pkg::ResW-1:0]     rem_y,
    input  logic        [tfn_pkg::ResW-1:0]     rem_z,
    output logic                                out_valid,
    output tfn_pkg::side_t                      side_out,
    output logic        [tfn_pkg::RootSteps-1:0] quo_x,
    output logic        [tfn_pkg::RootSteps-1:0] quo_y,
    output logic        [tfn_pkg::RootSteps-1:0] quo_z
);
    import tfn_pkg::*;

    logic                 v_reg   [RootSteps];
    side_t                s_reg   [RootSteps];
    logic [SumW-1:0]      len_reg [RootSteps];
    logic [ResW-1:0]      rem_reg [RootSteps][Axes];
    logic [AccW-1:0]      acc_reg [RootSteps][Axes];
    logic [RootSteps-1:0] quo_reg [RootSteps][Axes];

    // invariant: rem = n^2 * 2^30 - q^2 * len_sq, acc = q * len_sq
    for (genvar i = 0; i < RootSteps; i++)
    begin : g_step
        localparam int B = RootSteps - 1 - i;

        logic                 v_in;
        side_t                s_in;
        logic [SumW-1:0]      len_in;
        logic [ResW-1:0]      rem_in [Axes];
        logic [AccW-1:0]      acc_in [Axes];
        logic [RootSteps-1:0] quo_in [Axes];
        logic [ResW-1:0]      cand   [Axes];
        logic [ResW-1:0]      rem_next [Axes];
        logic [AccW-1:0]      acc_next [Axes];
        logic [RootSteps-1:0] quo_next [Axes];

        if (i == 0)
        begin : g_first
            assign v_in      = in_valid;
            assign s_in      = side_in;
            assign len_in    = len_sq;
            assign rem_in[0] = rem_x;
            assign rem_in[1] = rem_y;
            assign rem_in[2] = rem_z;
            for (genvar k = 0; k < Axes; k++)
            begin : g_clr
                assign acc_in[k] = '0;
                assign quo_in[k] = '0;
            end
        end
        else
        begin : g_next
            assign v_in   = v_reg[i-1];
            assign s_in   = s_reg[i-1];
            assign len_in = len_reg[i-1];
            for (genvar k = 0; k < Axes; k++)
            begin : g_cp
                assign rem_in[k] = rem_reg[i-1][k];
                assign acc_in[k] = acc_reg[i-1][k];
                assign quo_in[k] = quo_reg[i-1][k];
            end
        end

        always_comb
        begin
            for (int k = 0; k < Axes; k++)
            begin
                cand[k] = (ResW'(acc_in[k]) << (B + 1)) + (ResW'(len_in) << (2 * B));
                if (cand[k] <= rem_in[k])
                begin
                    rem_next[k] = rem_in[k] - cand[k];
                    acc_next[k] = acc_in[k] + (AccW'(len_in) << B);
                    quo_next[k] = quo_in[k] | (RootSteps'(1) << B);
                end
                else
                begin
                    rem_next[k] = rem_in[k];
                    acc_next[k] = acc_in[k];
                    quo_next[k] = quo_in[k];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            s_reg[i]   <= s_in;
            len_reg[i] <= len_in;
            for (int k = 0; k < Axes; k++)
            begin
                rem_reg[i][k] <= rem_next[k];
                acc_reg[i][k] <= acc_next[k];
                quo_reg[i][k] <= quo_next[k];
            end
        end
    end

    assign out_valid = v_reg[RootSteps-1];
    assign side_out  = s_reg[RootSteps-1];
    assign quo_x     = quo_reg[RootSteps-1][0];
    assign quo_y     = quo_reg[RootSteps-1][1];
    assign quo_z     = quo_reg[RootSteps-1][2];

endmodule
